// ===== hdl/mpm_pkg.sv =====
// shared types and constants of the multi-pattern matcher
package mpm_pkg;

  // results one scanned symbol may report at most
  localparam int MAX_RESULTS = 16;
  // depth of the command queue between front and engine
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_SCAN  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SYMBOL    = 3'd1,
    ERR_STATES    = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_PATTERNS  = 3'd4,
    ERR_ALPHABET  = 3'd5,
    ERR_NOT_BUILT = 3'd6
  } err_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESULT,
    ST_LD_WAIT,
    ST_LD_CHK,
    ST_BD_INIT,
    ST_BD_CWAIT,
    ST_BD_CCHK,
    ST_BD_WWAIT,
    ST_BD_WCHK,
    ST_BD_LWAIT,
    ST_BD_LINK,
    ST_BD_NEXT,
    ST_BD_QNEXT,
    ST_BD_QWAIT,
    ST_BD_FRWAIT,
    ST_BD_FRGET,
    ST_SC_WAIT,
    ST_SC_WCHK,
    ST_SC_NWAIT,
    ST_SC_EMIT
  } eng_state_e;

  // classified command handed from front to engine
  typedef struct packed {
    req_e        op;
    err_e        err;
    logic [7:0]  col;
    logic [7:0]  span;
    logic        eow;
    logic        sot;
  } cmd_t;

endpackage

// ===== hdl/multi_pattern_matcher.sv =====
// top level of the multi-pattern matcher
//
// Aho-Corasick automaton. Patterns are loaded one symbol per beat into a trie,
// a build beat computes failure and suffix output links breadth first, and
// scan beats then report up to MAX_RESULTS patterns ending at each text symbol,
// longest first, each as its own result beat with last set on the final one. A
// front end classifies each input beat (alphabet and symbol checks) into a
// two-entry command queue; the engine behind it owns the trie memories and
// runs one command at a time, and its registered output lets the front keep
// accepting while a result waits. After reset the engine clears the goto
// memory (MAX_STATES * 2^ceil(log2(ALPHABET)) entries, 8192 by default) and the
// pattern memory, one entry per cycle; in_ready_o stays low during that pass.
// Every memory read is registered. A scan follows failure links until a goto
// entry is found and then reports one match per result beat along the output
// links; a build visits every column of the root and of every trie state and
// walks failure links for each trie edge below the root; a stalled result beat
// holds the engine until it is taken. Configuration must be written only while
// the block is idle, and a write forces a rebuild before the next scan.
module multi_pattern_matcher #(
  parameter int MAX_STATES      = 256,
  parameter int ALPHABET        = 32,
  parameter int MAX_PATTERNS    = 64,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // request beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  symbol_i,
  input  logic        end_of_word_i,
  input  logic        start_of_text_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] position_o,
  output logic [5:0]  pattern_id_o,
  output logic        last_o
);

  import mpm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop, eng_ready;

  // classification and command queue
  mpm_front #(.ALPHABET(ALPHABET)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .symbol_i        (symbol_i),
    .end_of_word_i   (end_of_word_i),
    .start_of_text_i (start_of_text_i),
    .eng_ready_i     (eng_ready),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // trie memories and sequencer
  mpm_engine #(
    .MAX_STATES      (MAX_STATES),
    .ALPHABET        (ALPHABET),
    .MAX_PATTERNS    (MAX_PATTERNS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .cfg_clr_i    (cfg_we_i),
    .ready_o      (eng_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .position_o   (position_o),
    .pattern_id_o (pattern_id_o),
    .last_o       (last_o)
  );

endmodule

// ===== hdl/mpm_ram.sv =====
// generic simple dual-port ram with registered read
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/mpm_front.sv =====
// front end: config registers, request classification and command queue
module mpm_front #(
  parameter int ALPHABET = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [7:0]    symbol_i,
  input  logic          end_of_word_i,
  input  logic          start_of_text_i,
  input  logic          eng_ready_i,
  output logic          cmd_valid_o,
  output mpm_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  import mpm_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [7:0] first_q, last_q;
  logic [7:0] span;
  logic       alpha_ok, in_range, push, known;
  cmd_t       cmd;

  cmd_t         q_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 8'd0;
      last_q  <= 8'd31;
    end else if (cfg_we_i) begin
      if (cfg_idx_i) begin
        last_q <= cfg_wdata_i;
      end else begin
        first_q <= cfg_wdata_i;
      end
    end
  end

  assign span     = last_q - first_q;
  assign alpha_ok = (last_q > first_q) && ({1'b0, span} < 9'(ALPHABET));
  assign in_range = (symbol_i >= first_q) && (symbol_i <= last_q);

  always_comb begin
    cmd.op   = req_e'(req_type_i);
    cmd.err  = ERR_NONE;
    cmd.col  = symbol_i - first_q;
    cmd.span = span;
    cmd.eow  = end_of_word_i;
    cmd.sot  = start_of_text_i;
    known    = 1'b0;
    case (req_e'(req_type_i))
      REQ_LOAD, REQ_SCAN: begin
        known = 1'b1;
        if (!alpha_ok) begin
          cmd.err = ERR_ALPHABET;
        end else if (!in_range) begin
          cmd.err = ERR_SYMBOL;
        end
      end
      REQ_BUILD: begin
        known = 1'b1;
        if (!alpha_ok) begin
          cmd.err = ERR_ALPHABET;
        end
      end
      default: known = 1'b0;
    endcase
  end

  // request code 3 is swallowed here
  assign in_ready_o  = eng_ready_i && (cnt_q < (QAW+1)'(QDEPTH));
  assign push        = in_valid_i && in_ready_o && known;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(cmd_pop_i);
    end
  end

endmodule

// ===== hdl/mpm_engine.sv =====
// back end: trie memories and the load, build and scan sequencer
module mpm_engine #(
  parameter int MAX_STATES      = 256,
  parameter int ALPHABET        = 32,
  parameter int MAX_PATTERNS    = 64,
  parameter int MAX_PATTERN_LEN = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  mpm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          cfg_clr_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [2:0]    error_code_o,
  output logic [31:0]   position_o,
  output logic [5:0]    pattern_id_o,
  output logic          last_o
);

  import mpm_pkg::*;

  localparam int SW     = $clog2(MAX_STATES);
  localparam int CW     = $clog2(ALPHABET);
  localparam int GAW    = SW + CW;
  localparam int GDEPTH = MAX_STATES * (2 ** CW);
  localparam int PCW    = $clog2(MAX_PATTERNS + 1);
  localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
  localparam int NW     = $clog2(MAX_RESULTS);
  localparam logic [SW:0]  MaxSt  = (SW+1)'(MAX_STATES);
  localparam logic [SW:0]  NoLink = {1'b1, {SW{1'b0}}};
  localparam logic [PCW-1:0] MaxPat = PCW'(MAX_PATTERNS);
  localparam logic [LW-1:0]  MaxLen = LW'(MAX_PATTERN_LEN);

  eng_state_e state_q, state_d;

  logic [GAW-1:0] clr_q, clr_d;
  logic [SW:0]    states_used_q, states_used_d, head_q, head_d, tail_q, tail_d;
  logic [PCW-1:0] pats_q, pats_d;
  logic [SW-1:0]  cursor_q, cursor_d, scan_st_q, scan_st_d;
  logic [LW-1:0]  len_q, len_d;
  logic [31:0]    scan_pos_q, scan_pos_d, pos_q, pos_d;
  logic           built_q, built_d, root_q, root_d;
  logic [SW-1:0]  x_q, x_d, r_q, r_d, fr_q, fr_d, s_q, s_d;
  logic [CW-1:0]  c_q, c_d;
  logic [NW-1:0]  n_q, n_d;
  kind_e          res_kind_q, res_kind_d;
  err_e           res_err_q, res_err_d;
  cmd_t           cmd_q, cmd_d;

  logic           out_valid_q, out_valid_d, out_load, can_emit;
  kind_e          out_kind_q, out_kind;
  err_e           out_err_q, out_err;
  logic [31:0]    out_pos_q, out_pos;
  logic [5:0]     out_pid_q, out_pid;
  logic           out_last_q, out_last;

  // memory ports
  logic           g_we;
  logic [GAW-1:0] g_waddr;
  logic [SW-1:0]  g_wdata, g_rdata;
  logic           f_we;
  logic [SW-1:0]  f_waddr, f_wdata, f_rdata;
  logic           o_we;
  logic [SW-1:0]  o_waddr;
  logic [SW:0]    o_wdata, o_rdata;
  logic           p_we;
  logic [SW-1:0]  p_waddr;
  logic [PCW-1:0] p_wdata, p_rdata;
  logic           q_we;
  logic [SW-1:0]  q_wdata, q_rdata;
  logic [SW-1:0]  nxt;
  logic           emit_last;

  mpm_ram #(.WIDTH(SW), .DEPTH(GDEPTH)) u_goto (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i({x_q, c_q}), .rdata_o(g_rdata)
  );

  mpm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_fail (
    .clk_i(clk_i), .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(x_q), .rdata_o(f_rdata)
  );

  mpm_ram #(.WIDTH(SW + 1), .DEPTH(MAX_STATES)) u_outl (
    .clk_i(clk_i), .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(x_q), .rdata_o(o_rdata)
  );

  mpm_ram #(.WIDTH(PCW), .DEPTH(MAX_STATES)) u_pat (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(x_q), .rdata_o(p_rdata)
  );

  mpm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_bfsq (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(tail_q[SW-1:0]), .wdata_i(q_wdata),
    .raddr_i(head_q[SW-1:0]), .rdata_o(q_rdata)
  );

  assign can_emit  = !out_valid_q || out_ready_i;
  assign ready_o   = (state_q != ST_CLEAR);
  assign nxt       = (g_rdata != '0) ? g_rdata : states_used_q[SW-1:0];
  assign emit_last = o_rdata[SW] || (n_q == NW'(MAX_RESULTS - 1));
  // root children are pushed straight from the read data
  assign q_wdata   = (state_q == ST_BD_CCHK) ? g_rdata : s_q;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    states_used_d = states_used_q;
    head_d        = head_q;
    tail_d        = tail_q;
    pats_d        = pats_q;
    cursor_d      = cursor_q;
    scan_st_d     = scan_st_q;
    len_d         = len_q;
    scan_pos_d    = scan_pos_q;
    pos_d         = pos_q;
    built_d       = built_q;
    root_d        = root_q;
    x_d           = x_q;
    r_d           = r_q;
    fr_d          = fr_q;
    s_d           = s_q;
    c_d           = c_q;
    n_d           = n_q;
    res_kind_d    = res_kind_q;
    res_err_d     = res_err_q;
    cmd_d         = cmd_q;
    cmd_pop_o     = 1'b0;
    out_load      = 1'b0;
    out_kind      = KIND_MATCH;
    out_err       = ERR_NONE;
    out_pos       = '0;
    out_pid       = '0;
    out_last      = 1'b1;
    g_we          = 1'b0;
    g_waddr       = {x_q, c_q};
    g_wdata       = states_used_q[SW-1:0];
    f_we          = 1'b0;
    f_waddr       = s_q;
    f_wdata       = x_q;
    o_we          = 1'b0;
    o_waddr       = s_q;
    o_wdata       = (p_rdata != '0) ? {1'b0, x_q} : o_rdata;
    p_we          = 1'b0;
    p_waddr       = nxt;
    p_wdata       = pats_q + 1'b1;
    q_we          = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        g_wdata = '0;
        p_we    = 1'b1;
        p_waddr = clr_q[SW-1:0];
        p_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          c_d       = cmd_i.col[CW-1:0];
          n_d       = '0;
          res_kind_d = KIND_REJECT;
          res_err_d  = cmd_i.err;
          case (cmd_i.op)
            REQ_LOAD: begin
              if (cmd_i.err != ERR_NONE) begin
                state_d = ST_RESULT;
              end else if (len_q >= MaxLen) begin
                res_err_d = ERR_LENGTH;
                cursor_d  = '0;
                len_d     = '0;
                state_d   = ST_RESULT;
              end else if (cmd_i.eow && (pats_q >= MaxPat)) begin
                res_err_d = ERR_PATTERNS;
                cursor_d  = '0;
                len_d     = '0;
                state_d   = ST_RESULT;
              end else begin
                x_d     = cursor_q;
                state_d = ST_LD_WAIT;
              end
            end
            REQ_BUILD: begin
              state_d = (cmd_i.err != ERR_NONE) ? ST_RESULT : ST_BD_INIT;
            end
            REQ_SCAN: begin
              if (!built_q) begin
                res_err_d = ERR_NOT_BUILT;
                state_d   = ST_RESULT;
              end else if (cmd_i.err != ERR_NONE) begin
                state_d = ST_RESULT;
              end else begin
                x_d        = cmd_i.sot ? '0 : scan_st_q;
                pos_d      = cmd_i.sot ? '0 : scan_pos_q;
                scan_pos_d = (cmd_i.sot ? 32'd0 : scan_pos_q) + 32'd1;
                state_d    = ST_SC_WAIT;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_RESULT: begin
        if (can_emit) begin
          out_load = 1'b1;
          out_kind = res_kind_q;
          out_err  = res_err_q;
          state_d  = ST_IDLE;
        end
      end

      ST_LD_WAIT: state_d = ST_LD_CHK;

      ST_LD_CHK: begin
        state_d = ST_IDLE;
        if ((g_rdata == '0) && (states_used_q >= MaxSt)) begin
          res_kind_d = KIND_REJECT;
          res_err_d  = ERR_STATES;
          cursor_d   = '0;
          len_d      = '0;
          state_d    = ST_RESULT;
        end else begin
          if (g_rdata == '0) begin
            g_we          = 1'b1;
            states_used_d = states_used_q + 1'b1;
          end
          built_d  = 1'b0;
          cursor_d = nxt;
          len_d    = len_q + 1'b1;
          if (cmd_q.eow) begin
            p_we     = 1'b1;
            pats_d   = pats_q + 1'b1;
            cursor_d = '0;
            len_d    = '0;
          end
        end
      end

      ST_BD_INIT: begin
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = '0;
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = NoLink;
        root_d  = 1'b1;
        x_d     = '0;
        r_d     = '0;
        c_d     = '0;
        head_d  = '0;
        tail_d  = '0;
        state_d = ST_BD_CWAIT;
      end

      ST_BD_CWAIT: state_d = ST_BD_CCHK;

      ST_BD_CCHK: begin
        s_d = g_rdata;
        if (g_rdata == '0) begin
          state_d = ST_BD_NEXT;
        end else if (root_q) begin
          f_we    = 1'b1;
          f_waddr = g_rdata;
          f_wdata = '0;
          o_we    = 1'b1;
          o_waddr = g_rdata;
          o_wdata = NoLink;
          state_d = ST_BD_NEXT;
        end else begin
          x_d     = fr_q;
          state_d = ST_BD_WWAIT;
        end
      end

      ST_BD_WWAIT: state_d = ST_BD_WCHK;

      // failure walk: goto and failure entries of x arrive together
      ST_BD_WCHK: begin
        if (g_rdata != '0) begin
          x_d     = g_rdata;
          state_d = ST_BD_LWAIT;
        end else if (x_q == '0) begin
          state_d = ST_BD_LWAIT;
        end else begin
          x_d     = f_rdata;
          state_d = ST_BD_WWAIT;
        end
      end

      ST_BD_LWAIT: state_d = ST_BD_LINK;

      ST_BD_LINK: begin
        f_we    = 1'b1;
        o_we    = 1'b1;
        state_d = ST_BD_NEXT;
      end

      ST_BD_NEXT: begin
        x_d = r_q;
        if (c_q == cmd_q.span[CW-1:0]) begin
          state_d = ST_BD_QNEXT;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = ST_BD_CWAIT;
        end
      end

      ST_BD_QNEXT: begin
        root_d = 1'b0;
        if (head_q < tail_q) begin
          state_d = ST_BD_QWAIT;
        end else begin
          built_d    = 1'b1;
          scan_st_d  = '0;
          scan_pos_d = '0;
          res_kind_d = KIND_BUILD;
          res_err_d  = ERR_NONE;
          state_d    = ST_RESULT;
        end
      end

      ST_BD_QWAIT: begin
        r_d     = q_rdata;
        x_d     = q_rdata;
        head_d  = head_q + 1'b1;
        state_d = ST_BD_FRWAIT;
      end

      ST_BD_FRWAIT: state_d = ST_BD_FRGET;

      ST_BD_FRGET: begin
        fr_d    = f_rdata;
        c_d     = '0;
        state_d = ST_BD_CWAIT;
      end

      ST_SC_WAIT: state_d = ST_SC_WCHK;

      ST_SC_WCHK: begin
        if (g_rdata != '0) begin
          x_d       = g_rdata;
          scan_st_d = g_rdata;
          state_d   = ST_SC_NWAIT;
        end else if (x_q == '0) begin
          scan_st_d = '0;
          state_d   = ST_SC_NWAIT;
        end else begin
          x_d     = f_rdata;
          state_d = ST_SC_WAIT;
        end
      end

      ST_SC_NWAIT: state_d = ST_SC_EMIT;

      // report the pattern at x, if any, then follow its output link
      ST_SC_EMIT: begin
        if (p_rdata != '0) begin
          if (can_emit) begin
            out_load = 1'b1;
            out_kind = KIND_MATCH;
            out_pos  = pos_q;
            out_pid  = 6'(p_rdata - 1'b1);
            out_last = emit_last;
            n_d      = n_q + 1'b1;
            if (emit_last) begin
              state_d = ST_IDLE;
            end else begin
              x_d     = o_rdata[SW-1:0];
              state_d = ST_SC_NWAIT;
            end
          end
        end else if (o_rdata[SW]) begin
          state_d = ST_IDLE;
        end else begin
          x_d     = o_rdata[SW-1:0];
          state_d = ST_SC_NWAIT;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    q_we = ((state_q == ST_BD_LINK) ||
            ((state_q == ST_BD_CCHK) && root_q && (g_rdata != '0))) && (tail_q < MaxSt);
    if (q_we) begin
      tail_d = tail_q + 1'b1;
    end
    if (state_q == ST_BD_CCHK) begin
      s_d = g_rdata;
    end
    if (cfg_clr_i) begin
      built_d = 1'b0;
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= '0;
      states_used_q <= (SW+1)'(1);
      head_q        <= '0;
      tail_q        <= '0;
      pats_q        <= '0;
      cursor_q      <= '0;
      scan_st_q     <= '0;
      len_q         <= '0;
      scan_pos_q    <= '0;
      built_q       <= 1'b0;
      root_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      clr_q         <= clr_d;
      states_used_q <= states_used_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      pats_q        <= pats_d;
      cursor_q      <= cursor_d;
      scan_st_q     <= scan_st_d;
      len_q         <= len_d;
      scan_pos_q    <= scan_pos_d;
      built_q       <= built_d;
      root_q        <= root_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    r_q        <= r_d;
    fr_q       <= fr_d;
    s_q        <= s_d;
    c_q        <= c_d;
    n_q        <= n_d;
    pos_q      <= pos_d;
    res_kind_q <= res_kind_d;
    res_err_q  <= res_err_d;
    cmd_q      <= cmd_d;
    if (out_load) begin
      out_kind_q <= out_kind;
      out_err_q  <= out_err;
      out_pos_q  <= out_pos;
      out_pid_q  <= out_pid;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign error_code_o = out_err_q;
  assign position_o   = out_pos_q;
  assign pattern_id_o = out_pid_q;
  assign last_o       = out_last_q;

endmodule
